FILE: rtl/core/multi_motor_pid_speed_drive_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-motor PID speed drive
// Concurrent checks sampled on the block clock, off while reset is held.
// ----------------------------------------------------------------------------
`ifndef MULTI_MOTOR_PID_SPEED_DRIVE_MACROS_SVH
`define MULTI_MOTOR_PID_SPEED_DRIVE_MACROS_SVH

// Same-cycle implication.
`define MMPSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MMPSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/mmpsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmpsd_pkg
// Widths, constants and register codes of the multi-motor PID speed drive.
// ----------------------------------------------------------------------------
package mmpsd_pkg;

    localparam int MOTOR_W    = 2;
    localparam int VAL_W      = 16;
    localparam int ELAPSED_W  = 8;
    localparam int DUTY_W     = 10;
    localparam int INT_LIM_W  = 20;

    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int K_W        = 17;
    localparam int DEN_W      = 15;
    localparam int MAG_W      = 33;
    localparam int CNT_W      = 6;
    localparam int ERR_W      = 27;
    localparam int INTEG_W    = 22;
    localparam int DIFF_W     = 28;
    localparam int MUL_A_W    = 28;
    localparam int MUL_B_W    = 18;
    localparam int PROD_W     = 46;
    localparam int ACC_W      = 48;
    localparam int DRIVE_W    = 17;

    localparam int TARGET_SCALE = 308;
    localparam int TIME_SCALE   = 100;
    localparam int COUNT_SCALE  = 100000;

    localparam logic [VAL_W-1:0]     OUT_LIMIT_RST = 16'd1000;
    localparam logic [INT_LIM_W-1:0] INT_LIMIT_RST = 20'd20000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE     = 3'd0,
        CFG_PID_MODE   = 3'd1,
        CFG_INVERT     = 3'd2,
        CFG_GAIN_P     = 3'd3,
        CFG_GAIN_I     = 3'd4,
        CFG_GAIN_D     = 3'd5,
        CFG_OUT_LIMIT  = 3'd6,
        CFG_INT_LIMIT  = 3'd7
    } t_cfg_idx;

endpackage

FILE: rtl/core/multi_motor_pid_speed_drive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_motor_pid_speed_drive
// Per-motor PID speed loop with integral clamp, output saturation and
// direction/duty split, computed on one shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
//  Channel  Direction  Ports                        Word
//  s        in         i_s_tvalid/o_s_tready        one control tick
//  m        out        o_m_tvalid/i_m_tready        one PWM compare update
//  cfg      in         i_cfg_valid/o_cfg_ready      register index and data
//
//  A PID word runs the target and count multiplier passes, the one-bit-per-cycle
//  divide, then the error, integral, gain multiplier, sum, scale and output steps
//  before the next word can be accepted. An open-loop word goes straight to
//  the output step. Disabled or out-of-range words are dropped at accept.
//  Reset is synchronous and clears state, config registers and the per-motor stores.
//  A stalled result sits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module multi_motor_pid_speed_drive #(
    parameter int NUM_MOTORS     = 4,
    parameter int DUTY_LIMIT     = 1023,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // motor_index [1:0], target [17:2], count_delta [33:18],
    // elapsed_ms [41:34], zero fill [47:42]
    input  logic [mmpsd_pkg::S_TDATA_W-1:0]     i_s_tdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // motor_out [1:0], reverse_dir [2], duty [12:3], zero fill [15:13]
    output logic [mmpsd_pkg::M_TDATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mmpsd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mmpsd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

`include "multi_motor_pid_speed_drive_macros.svh"

    localparam int MIDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_T, S_MUL_C, S_DIV_INIT, S_DIV, S_ERR, S_INTEG,
        S_MUL_P, S_MUL_I, S_MUL_D, S_SUM, S_SCALE, S_OUT
    } t_state;

    t_state r_state;

    logic                                   r_enable;
    logic                                   r_pid_mode;
    logic                                   r_invert;
    logic signed [mmpsd_pkg::VAL_W-1:0]     r_gain_p;
    logic signed [mmpsd_pkg::VAL_W-1:0]     r_gain_i;
    logic signed [mmpsd_pkg::VAL_W-1:0]     r_gain_d;
    logic [mmpsd_pkg::VAL_W-1:0]            r_out_lim;
    logic [mmpsd_pkg::INT_LIM_W-1:0]        r_int_lim;

    logic signed [mmpsd_pkg::INTEG_W-1:0]   r_integ_store [NUM_MOTORS];
    logic signed [mmpsd_pkg::ERR_W-1:0]     r_last_store  [NUM_MOTORS];

    logic [mmpsd_pkg::MOTOR_W-1:0]          r_motor;
    logic signed [mmpsd_pkg::VAL_W-1:0]     r_target;
    logic signed [mmpsd_pkg::VAL_W-1:0]     r_delta;
    logic [mmpsd_pkg::K_W-1:0]              r_k;
    logic [mmpsd_pkg::DEN_W-1:0]            r_den;
    logic                                   r_pid_item;

    logic signed [mmpsd_pkg::PROD_W-1:0]    r_prod;
    logic signed [mmpsd_pkg::ACC_W-1:0]     r_acc;
    logic                                   r_neg;
    logic [mmpsd_pkg::MAG_W-1:0]            r_quo;
    logic [mmpsd_pkg::DEN_W-1:0]            r_rem;
    logic [mmpsd_pkg::CNT_W-1:0]            r_cnt;
    logic signed [mmpsd_pkg::ERR_W-1:0]     r_err;
    logic signed [mmpsd_pkg::INTEG_W-1:0]   r_integ;
    logic signed [mmpsd_pkg::DIFF_W-1:0]    r_diff;
    logic signed [mmpsd_pkg::DRIVE_W-1:0]   r_drive;

    logic                                   r_out_valid;
    logic [mmpsd_pkg::M_TDATA_W-1:0]        r_out_data;

    logic [mmpsd_pkg::MOTOR_W-1:0]          w_in_motor;
    logic [mmpsd_pkg::ELAPSED_W-1:0]        w_in_e;
    logic [mmpsd_pkg::ELAPSED_W-1:0]        w_e;
    logic                                   w_in_range;
    logic [3:0]                             w_motor_ext;
    logic [MIDX_W-1:0]                      w_midx;

    logic signed [mmpsd_pkg::MUL_A_W-1:0]   w_mul_a;
    logic signed [mmpsd_pkg::MUL_B_W-1:0]   w_mul_b;
    logic signed [mmpsd_pkg::PROD_W-1:0]    w_mul_p;
    logic signed [mmpsd_pkg::ACC_W-1:0]     w_prod_ext;
    logic signed [mmpsd_pkg::ACC_W-1:0]     w_num;
    logic signed [mmpsd_pkg::ACC_W-1:0]     w_num_neg;
    logic [mmpsd_pkg::MAG_W-1:0]            w_num_mag;

    logic [mmpsd_pkg::DEN_W+1:0]            w_trial;
    logic [mmpsd_pkg::ERR_W-1:0]            w_qmag;
    logic signed [mmpsd_pkg::ERR_W-1:0]     w_err;

    logic signed [mmpsd_pkg::DIFF_W:0]      w_isum;
    logic signed [mmpsd_pkg::DIFF_W:0]      w_ilim;
    logic signed [mmpsd_pkg::INTEG_W-1:0]   w_integ;
    logic signed [mmpsd_pkg::DIFF_W-1:0]    w_diff;

    logic signed [mmpsd_pkg::ACC_W-1:0]     w_shift;
    logic signed [mmpsd_pkg::ACC_W-1:0]     w_olim;
    logic signed [mmpsd_pkg::DRIVE_W-1:0]   w_drive_cl;

    logic signed [mmpsd_pkg::DRIVE_W-1:0]   w_drive_fin;
    logic signed [mmpsd_pkg::DRIVE_W-1:0]   w_drive_neg;
    logic [mmpsd_pkg::VAL_W-1:0]            w_mag;
    logic [mmpsd_pkg::VAL_W-1:0]            w_mag_cl;
    logic                                   w_out_load;

    logic signed [mmpsd_pkg::DRIVE_W-1:0]   w_chk_olim;
    logic signed [mmpsd_pkg::INTEG_W-1:0]   w_chk_ilim;
    logic                                   w_chk_drive_ok;
    logic                                   w_chk_integ_ok;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    assign w_in_motor  = i_s_tdata[1:0];
    assign w_in_e      = i_s_tdata[41:34];
    assign w_e         = (w_in_e == '0) ? 8'd1 : w_in_e;
    assign w_in_range  = ({3'b000, w_in_motor} < 5'(NUM_MOTORS));
    assign w_motor_ext = {2'b00, r_motor};
    assign w_midx      = w_motor_ext[MIDX_W-1:0];

    always_comb begin
        unique case (r_state)
            S_MUL_T: begin
                w_mul_a = mmpsd_pkg::MUL_A_W'(r_target);
                w_mul_b = signed'({1'b0, r_k});
            end
            S_MUL_C: begin
                w_mul_a = mmpsd_pkg::MUL_A_W'(r_delta);
                w_mul_b = mmpsd_pkg::MUL_B_W'(mmpsd_pkg::COUNT_SCALE);
            end
            S_MUL_P: begin
                w_mul_a = mmpsd_pkg::MUL_A_W'(r_err);
                w_mul_b = mmpsd_pkg::MUL_B_W'(r_gain_p);
            end
            S_MUL_I: begin
                w_mul_a = mmpsd_pkg::MUL_A_W'(r_integ);
                w_mul_b = mmpsd_pkg::MUL_B_W'(r_gain_i);
            end
            S_MUL_D: begin
                w_mul_a = r_diff;
                w_mul_b = mmpsd_pkg::MUL_B_W'(r_gain_d);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p    = w_mul_a * w_mul_b;
    assign w_prod_ext = mmpsd_pkg::ACC_W'(r_prod);

    assign w_num      = r_acc - w_prod_ext;
    assign w_num_neg  = -w_num;
    assign w_num_mag  = w_num[mmpsd_pkg::ACC_W-1] ? w_num_neg[mmpsd_pkg::MAG_W-1:0]
                                                  : w_num[mmpsd_pkg::MAG_W-1:0];

    assign w_trial = {1'b0, r_rem, r_quo[mmpsd_pkg::MAG_W-1]} - {2'b00, r_den};
    assign w_qmag  = r_quo[mmpsd_pkg::ERR_W-1:0];
    assign w_err   = r_neg ? -signed'(w_qmag) : signed'(w_qmag);

    assign w_isum = (mmpsd_pkg::DIFF_W+1)'(r_integ_store[w_midx])
                  + (mmpsd_pkg::DIFF_W+1)'(r_err);
    assign w_ilim = signed'({9'b0, r_int_lim});
    assign w_diff = mmpsd_pkg::DIFF_W'(r_err) - mmpsd_pkg::DIFF_W'(r_last_store[w_midx]);

    always_comb begin
        priority if (w_isum > w_ilim) begin
            w_integ = w_ilim[mmpsd_pkg::INTEG_W-1:0];
        end else if (w_isum < -w_ilim) begin
            w_integ = mmpsd_pkg::INTEG_W'(-w_ilim);
        end else begin
            w_integ = w_isum[mmpsd_pkg::INTEG_W-1:0];
        end
    end

    assign w_shift = r_acc >>> GAIN_FRAC_BITS;
    assign w_olim  = signed'({32'b0, r_out_lim});

    always_comb begin
        priority if (w_shift > w_olim) begin
            w_drive_cl = w_olim[mmpsd_pkg::DRIVE_W-1:0];
        end else if (w_shift < -w_olim) begin
            w_drive_cl = mmpsd_pkg::DRIVE_W'(-w_olim);
        end else begin
            w_drive_cl = w_shift[mmpsd_pkg::DRIVE_W-1:0];
        end
    end

    assign w_drive_fin = r_invert ? -r_drive : r_drive;
    assign w_drive_neg = -w_drive_fin;
    assign w_mag       = w_drive_fin[mmpsd_pkg::DRIVE_W-1] ? w_drive_neg[mmpsd_pkg::VAL_W-1:0]
                                                           : w_drive_fin[mmpsd_pkg::VAL_W-1:0];
    assign w_mag_cl    = (w_mag > 16'(DUTY_LIMIT)) ? 16'(DUTY_LIMIT) : w_mag;
    assign w_out_load  = (r_state == S_OUT) && (!r_out_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_pid_mode <= 1'b0;
            r_invert   <= 1'b0;
            r_gain_p   <= '0;
            r_gain_i   <= '0;
            r_gain_d   <= '0;
            r_out_lim  <= mmpsd_pkg::OUT_LIMIT_RST;
            r_int_lim  <= mmpsd_pkg::INT_LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (mmpsd_pkg::t_cfg_idx'(i_cfg_index))
                mmpsd_pkg::CFG_ENABLE:    r_enable   <= i_cfg_data[0];
                mmpsd_pkg::CFG_PID_MODE:  r_pid_mode <= i_cfg_data[0];
                mmpsd_pkg::CFG_INVERT:    r_invert   <= i_cfg_data[0];
                mmpsd_pkg::CFG_GAIN_P:    r_gain_p   <= signed'(i_cfg_data[15:0]);
                mmpsd_pkg::CFG_GAIN_I:    r_gain_i   <= signed'(i_cfg_data[15:0]);
                mmpsd_pkg::CFG_GAIN_D:    r_gain_d   <= signed'(i_cfg_data[15:0]);
                mmpsd_pkg::CFG_OUT_LIMIT: r_out_lim  <= i_cfg_data[15:0];
                mmpsd_pkg::CFG_INT_LIMIT: r_int_lim  <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pid_item  <= 1'b0;
            r_cnt       <= '0;
            for (int k = 0; k < NUM_MOTORS; k++) begin
                r_integ_store[k] <= '0;
                r_last_store[k]  <= '0;
            end
        end else begin
            if (i_m_tready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_motor    <= w_in_motor;
                        r_target   <= signed'(i_s_tdata[17:2]);
                        r_delta    <= signed'(i_s_tdata[33:18]);
                        r_k        <= mmpsd_pkg::K_W'(mmpsd_pkg::TARGET_SCALE * int'(w_e));
                        r_den      <= mmpsd_pkg::DEN_W'(mmpsd_pkg::TIME_SCALE * int'(w_e));
                        r_drive    <= mmpsd_pkg::DRIVE_W'(signed'(i_s_tdata[17:2]));
                        r_pid_item <= r_pid_mode;
                        if (r_enable && w_in_range) begin
                            r_state <= r_pid_mode ? S_MUL_T : S_OUT;
                        end
                    end
                end
                S_MUL_T: begin
                    r_prod  <= w_mul_p;
                    r_state <= S_MUL_C;
                end
                S_MUL_C: begin
                    r_prod  <= w_mul_p;
                    r_acc   <= w_prod_ext;
                    r_state <= S_DIV_INIT;
                end
                S_DIV_INIT: begin
                    r_neg   <= w_num[mmpsd_pkg::ACC_W-1];
                    r_quo   <= w_num_mag;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!w_trial[mmpsd_pkg::DEN_W+1]) begin
                        r_rem <= w_trial[mmpsd_pkg::DEN_W-1:0];
                        r_quo <= {r_quo[mmpsd_pkg::MAG_W-2:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[mmpsd_pkg::DEN_W-2:0], r_quo[mmpsd_pkg::MAG_W-1]};
                        r_quo <= {r_quo[mmpsd_pkg::MAG_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == mmpsd_pkg::CNT_W'(mmpsd_pkg::MAG_W - 1)) begin
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_err   <= w_err;
                    r_state <= S_INTEG;
                end
                S_INTEG: begin
                    r_integ               <= w_integ;
                    r_diff                <= w_diff;
                    r_integ_store[w_midx] <= w_integ;
                    r_last_store[w_midx]  <= r_err;
                    r_state               <= S_MUL_P;
                end
                S_MUL_P: begin
                    r_prod  <= w_mul_p;
                    r_state <= S_MUL_I;
                end
                S_MUL_I: begin
                    r_prod  <= w_mul_p;
                    r_acc   <= w_prod_ext;
                    r_state <= S_MUL_D;
                end
                S_MUL_D: begin
                    r_prod  <= w_mul_p;
                    r_acc   <= r_acc + w_prod_ext;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_acc   <= r_acc + w_prod_ext;
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_drive <= w_drive_cl;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {3'b000, w_mag_cl[mmpsd_pkg::DUTY_W-1:0],
                                        w_drive_fin[mmpsd_pkg::DRIVE_W-1], r_motor};
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign w_chk_olim     = signed'({1'b0, r_out_lim});
    assign w_chk_ilim     = signed'({2'b00, r_int_lim});
    assign w_chk_drive_ok = (r_drive <= w_chk_olim) && (r_drive >= -w_chk_olim);
    assign w_chk_integ_ok = (r_integ <= w_chk_ilim) && (r_integ >= -w_chk_ilim);

    `MMPSD_ASSERT_NOW(a_div_rem_below_den, r_state == S_DIV, r_rem < r_den, "remainder reached divisor")
    `MMPSD_ASSERT_NOW(a_integ_clamped, r_state == S_MUL_P, w_chk_integ_ok, "integral outside limit")
    `MMPSD_ASSERT_NOW(a_drive_saturated, (r_state == S_OUT) && r_pid_item, w_chk_drive_ok, "drive outside output limit")
    `MMPSD_ASSERT_NEXT(a_result_presented, w_out_load, o_m_tvalid && (r_state == S_IDLE), "result not presented")

endmodule
